/* sv/limit_order_book_matcher_macros.svh */
// assertion helpers for the order book matcher
`ifndef LIMIT_ORDER_BOOK_MATCHER_MACROS_SVH
`define LIMIT_ORDER_BOOK_MATCHER_MACROS_SVH
`ifndef SYNTHESIS
`define LOBM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("lobm check failed");
`define LOBM_ASSERT_IMP(lbl, a, b) \
  `LOBM_ASSERT(lbl, (a) |-> (b))
`else
`define LOBM_ASSERT(lbl, prop)
`define LOBM_ASSERT_IMP(lbl, a, b)
`endif
`endif

/* sv/lobm_pkg.sv */
package lobm_pkg;

  typedef struct packed {
    logic        valid;
    logic        side;
    logic [31:0] price;
    logic [23:0] qty;
    logic [31:0] id;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PASS,
    ST_DECIDE
  } state_t;

  typedef enum logic [1:0] {
    MODE_CANCEL,
    MODE_SEARCH,
    MODE_INSERT,
    MODE_REJECT
  } mode_t;

  localparam logic [3:0] EV_TRADE     = 4'd0;
  localparam logic [3:0] EV_RESTED    = 4'd1;
  localparam logic [3:0] EV_COMPLETE  = 4'd2;
  localparam logic [3:0] EV_MKT_CXL   = 4'd3;
  localparam logic [3:0] EV_CANCELLED = 4'd4;
  localparam logic [3:0] EV_NOT_FOUND = 4'd5;
  localparam logic [3:0] EV_BAD_QTY   = 4'd6;
  localparam logic [3:0] EV_BAD_PRICE = 4'd7;
  localparam logic [3:0] EV_BOOK_FULL = 4'd8;
  localparam logic [3:0] EV_IDS_OUT   = 4'd9;

  localparam logic KIND_ADD    = 1'b0;
  localparam logic KIND_CANCEL = 1'b1;
  localparam logic SIDE_BUY    = 1'b0;

endpackage

/* sv/lobm_cell.sv */
module lobm_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  lobm_pkg::entry_t d,
  output lobm_pkg::entry_t q
);
  import lobm_pkg::*;

  logic   valid_r;
  entry_t data_r;

  // only the valid bit needs reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= d;
    end
  end

  always_comb begin
    q       = data_r;
    q.valid = valid_r;
  end

endmodule

/* sv/limit_order_book_matcher.sv */
// price-time priority order book. the book is a ring of BOOK_DEPTH cells that rotates one
// cell per cycle while in a pass, past a single compare/update point at the head. every
// operation is done in passes over the whole ring: a cancel takes one pass, an add takes
// one pass per trade plus one (the pass that applies the last fill and finds nothing more),
// one more pass if a limit remainder has to rest, and a rejected add takes none. each result
// word is written in a decide step that waits while the output register is full and not
// being read. results leave through a one-word output register; the next input word is
// taken once the previous one has been fully answered.
`include "limit_order_book_matcher_macros.svh"
module limit_order_book_matcher #(
  parameter int BOOK_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic        in_side,
  input  logic        in_is_market,
  input  logic [31:0] in_price_ticks,
  input  logic [23:0] in_quantity,
  input  logic [31:0] in_cancel_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_event_res,
  output logic [31:0] out_order_id,
  output logic [31:0] out_buy_id,
  output logic [31:0] out_sell_id,
  output logic [31:0] out_trade_price,
  output logic [23:0] out_trade_qty,
  output logic        out_aggressor,
  output logic [23:0] out_left_qty,
  output logic        out_last
);
  import lobm_pkg::*;

  localparam int CW = $clog2(BOOK_DEPTH);
  localparam logic [CW-1:0] CNT_LAST = CW'(BOOK_DEPTH - 1);

  // ring of cells, head is cell 0, tail takes the processed head word
  entry_t cell_q [BOOK_DEPTH];
  entry_t head_mod;
  logic   rot;

  genvar g;
  generate
    for (g = 0; g < BOOK_DEPTH; g++) begin : g_cell
      entry_t cell_d;
      if (g == BOOK_DEPTH - 1) begin : g_tail
        assign cell_d = head_mod;
      end else begin : g_mid
        assign cell_d = cell_q[g+1];
      end
      lobm_cell u_cell (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (rot),
        .d    (cell_d),
        .q    (cell_q[g])
      );
    end
  endgenerate

  // control and operation registers
  state_t      state_r, state_nxt;
  mode_t       mode_r, mode_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic        side_r, side_nxt;
  logic        mkt_r, mkt_nxt;
  logic [31:0] price_r, price_nxt;
  logic [23:0] rem_r, rem_nxt;
  logic [31:0] cid_r, cid_nxt;
  logic [31:0] id_r, id_nxt;
  logic [31:0] next_id_r, next_id_nxt;
  logic [3:0]  rej_ev_r, rej_ev_nxt;
  // fill waiting to be applied to the resting order during the next pass
  logic        pend_r, pend_nxt;
  logic [31:0] pend_id_r, pend_id_nxt;
  logic [23:0] pend_q_r, pend_q_nxt;
  // best opposite order seen so far in the current pass
  logic        best_found_r, best_found_nxt;
  logic [31:0] best_price_r, best_price_nxt;
  logic [31:0] best_id_r, best_id_nxt;
  logic [23:0] best_qty_r, best_qty_nxt;
  // cancel hit or insert done during the pass
  logic        hit_r, hit_nxt;
  logic [23:0] hit_qty_r, hit_qty_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [3:0]  ev_r, ev_nxt;
  logic [31:0] oid_r, oid_nxt;
  logic [31:0] bid_r, bid_nxt;
  logic [31:0] sid_r, sid_nxt;
  logic [31:0] px_r, px_nxt;
  logic [23:0] tq_r, tq_nxt;
  logic        agg_r, agg_nxt;
  logic [23:0] left_r, left_nxt;
  logic        last_r, last_nxt;

  logic accept;
  logic emit_ok;
  logic in_reject;
  logic cand;
  logic better;
  logic [23:0] fill_q;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign emit_ok   = !out_valid_r || out_ready;
  assign rot       = (state_r == ST_PASS);
  assign in_reject = (in_quantity == 24'd0) || (!in_is_market && in_price_ticks == 32'd0)
                     || (next_id_r == 32'd0);
  assign fill_q    = (rem_r < best_qty_r) ? rem_r : best_qty_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_ADD && in_reject) state_nxt = ST_DECIDE;
          else state_nxt = ST_PASS;
        end
      end
      ST_PASS: begin
        if (cnt_r == CNT_LAST) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (emit_ok) begin
          if (mode_r == MODE_SEARCH) begin
            if (rem_r == 24'd0) state_nxt = ST_IDLE;
            else if (best_found_r) state_nxt = ST_PASS;
            else if (mkt_r) state_nxt = ST_IDLE;
            else state_nxt = ST_PASS;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // head processing: apply pending fill, then cancel, insert or search
  always_comb begin
    head_mod       = cell_q[0];
    hit_nxt        = hit_r;
    hit_qty_nxt    = hit_qty_r;
    best_found_nxt = best_found_r;
    best_price_nxt = best_price_r;
    best_id_nxt    = best_id_r;
    best_qty_nxt   = best_qty_r;
    cand           = 1'b0;
    better         = 1'b0;
    if (pend_r && head_mod.valid && head_mod.id == pend_id_r) begin
      head_mod.qty = head_mod.qty - pend_q_r;
      if (head_mod.qty == 24'd0) head_mod.valid = 1'b0;
    end
    case (mode_r)
      MODE_CANCEL: begin
        if (head_mod.valid && head_mod.id == cid_r && !hit_r) begin
          hit_nxt        = 1'b1;
          hit_qty_nxt    = head_mod.qty;
          head_mod.valid = 1'b0;
        end
      end
      MODE_INSERT: begin
        if (!head_mod.valid && !hit_r) begin
          head_mod.valid = 1'b1;
          head_mod.side  = side_r;
          head_mod.price = price_r;
          head_mod.qty   = rem_r;
          head_mod.id    = id_r;
          hit_nxt        = 1'b1;
        end
      end
      MODE_SEARCH: begin
        cand = head_mod.valid && head_mod.side != side_r && rem_r != 24'd0
               && (mkt_r || (side_r == SIDE_BUY ? head_mod.price <= price_r
                                                : head_mod.price >= price_r));
        if (!best_found_r) better = 1'b1;
        else if (head_mod.price == best_price_r) better = head_mod.id < best_id_r;
        else better = (side_r == SIDE_BUY) ? head_mod.price < best_price_r
                                           : head_mod.price > best_price_r;
        if (cand && better) begin
          best_found_nxt = 1'b1;
          best_price_nxt = head_mod.price;
          best_id_nxt    = head_mod.id;
          best_qty_nxt   = head_mod.qty;
        end
      end
      default: ;
    endcase
    if (state_r != ST_PASS) begin
      hit_nxt        = hit_r;
      hit_qty_nxt    = hit_qty_r;
      best_found_nxt = best_found_r;
      best_price_nxt = best_price_r;
      best_id_nxt    = best_id_r;
      best_qty_nxt   = best_qty_r;
    end
  end

  // operation registers and result words
  always_comb begin
    mode_nxt    = mode_r;
    cnt_nxt     = cnt_r;
    side_nxt    = side_r;
    mkt_nxt     = mkt_r;
    price_nxt   = price_r;
    rem_nxt     = rem_r;
    cid_nxt     = cid_r;
    id_nxt      = id_r;
    next_id_nxt = next_id_r;
    rej_ev_nxt  = rej_ev_r;
    pend_nxt    = pend_r;
    pend_id_nxt = pend_id_r;
    pend_q_nxt  = pend_q_r;

    out_valid_nxt = out_valid_r && !out_ready;
    ev_nxt   = ev_r;
    oid_nxt  = oid_r;
    bid_nxt  = bid_r;
    sid_nxt  = sid_r;
    px_nxt   = px_r;
    tq_nxt   = tq_r;
    agg_nxt  = agg_r;
    left_nxt = left_r;
    last_nxt = last_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          side_nxt  = in_side;
          mkt_nxt   = in_is_market;
          price_nxt = in_price_ticks;
          rem_nxt   = in_quantity;
          cid_nxt   = in_cancel_id;
          pend_nxt  = 1'b0;
          cnt_nxt   = '0;
          if (in_kind == KIND_CANCEL) begin
            mode_nxt = MODE_CANCEL;
          end else if (in_reject) begin
            mode_nxt = MODE_REJECT;
            if (in_quantity == 24'd0) rej_ev_nxt = EV_BAD_QTY;
            else if (!in_is_market && in_price_ticks == 32'd0) rej_ev_nxt = EV_BAD_PRICE;
            else rej_ev_nxt = EV_IDS_OUT;
          end else begin
            mode_nxt    = MODE_SEARCH;
            id_nxt      = next_id_r;
            next_id_nxt = next_id_r + 32'd1;
          end
        end
      end
      ST_PASS: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          cnt_nxt  = '0;
          pend_nxt = 1'b0;
        end
      end
      ST_DECIDE: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          oid_nxt  = id_r;
          bid_nxt  = '0;
          sid_nxt  = '0;
          px_nxt   = '0;
          tq_nxt   = '0;
          agg_nxt  = side_r;
          left_nxt = rem_r;
          last_nxt = 1'b1;
          case (mode_r)
            MODE_CANCEL: begin
              oid_nxt  = cid_r;
              agg_nxt  = 1'b0;
              ev_nxt   = hit_r ? EV_CANCELLED : EV_NOT_FOUND;
              left_nxt = hit_r ? hit_qty_r : 24'd0;
            end
            MODE_REJECT: begin
              ev_nxt   = rej_ev_r;
              oid_nxt  = '0;
              left_nxt = '0;
            end
            MODE_INSERT: begin
              ev_nxt = hit_r ? EV_RESTED : EV_BOOK_FULL;
            end
            MODE_SEARCH: begin
              if (rem_r == 24'd0) begin
                ev_nxt = EV_COMPLETE;
              end else if (best_found_r) begin
                // one fill against the best opposite order
                ev_nxt      = EV_TRADE;
                last_nxt    = 1'b0;
                bid_nxt     = (side_r == SIDE_BUY) ? id_r : best_id_r;
                sid_nxt     = (side_r == SIDE_BUY) ? best_id_r : id_r;
                px_nxt      = best_price_r;
                tq_nxt      = fill_q;
                left_nxt    = rem_r - fill_q;
                rem_nxt     = rem_r - fill_q;
                pend_nxt    = 1'b1;
                pend_id_nxt = best_id_r;
                pend_q_nxt  = fill_q;
              end else if (mkt_r) begin
                ev_nxt = EV_MKT_CXL;
              end else begin
                // limit remainder goes looking for a free cell
                out_valid_nxt = out_valid_r && !out_ready;
                mode_nxt      = MODE_INSERT;
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // best and hit trackers restart at every pass boundary
  logic pass_start;
  assign pass_start = (state_nxt == ST_PASS) && (state_r != ST_PASS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      mode_r       <= MODE_SEARCH;
      cnt_r        <= '0;
      next_id_r    <= 32'd1;
      pend_r       <= 1'b0;
      best_found_r <= 1'b0;
      hit_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      cnt_r        <= cnt_nxt;
      next_id_r    <= next_id_nxt;
      pend_r       <= pend_nxt;
      best_found_r <= pass_start ? 1'b0 : best_found_nxt;
      hit_r        <= pass_start ? 1'b0 : hit_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    side_r       <= side_nxt;
    mkt_r        <= mkt_nxt;
    price_r      <= price_nxt;
    rem_r        <= rem_nxt;
    cid_r        <= cid_nxt;
    id_r         <= id_nxt;
    rej_ev_r     <= rej_ev_nxt;
    pend_id_r    <= pend_id_nxt;
    pend_q_r     <= pend_q_nxt;
    best_price_r <= best_price_nxt;
    best_id_r    <= best_id_nxt;
    best_qty_r   <= best_qty_nxt;
    hit_qty_r    <= hit_qty_nxt;
    ev_r         <= ev_nxt;
    oid_r        <= oid_nxt;
    bid_r        <= bid_nxt;
    sid_r        <= sid_nxt;
    px_r         <= px_nxt;
    tq_r         <= tq_nxt;
    agg_r        <= agg_nxt;
    left_r       <= left_nxt;
    last_r       <= last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_event_res   = ev_r;
  assign out_order_id    = oid_r;
  assign out_buy_id      = bid_r;
  assign out_sell_id     = sid_r;
  assign out_trade_price = px_r;
  assign out_trade_qty   = tq_r;
  assign out_aggressor   = agg_r;
  assign out_left_qty    = left_r;
  assign out_last        = last_r;

  `LOBM_ASSERT_IMP(a_cnt_idle, state_r != ST_PASS, cnt_r == '0)
  `LOBM_ASSERT(a_pass_end, (state_r == ST_PASS && cnt_r == CNT_LAST) |=> state_r == ST_DECIDE)
  `LOBM_ASSERT_IMP(a_trade_qty, out_valid_r && ev_r == EV_TRADE, tq_r != 24'd0 && !last_r)
  `LOBM_ASSERT_IMP(a_pend_search, pend_r, mode_r == MODE_SEARCH || mode_r == MODE_INSERT)

endmodule
